// ----- rtl/core/pbu_pkg.sv -----
// Shared types, constants and control structs for the particle bounce update block.
package pbu_pkg;

  localparam int unsigned MAX_ENTITIES = 1024;
  localparam int unsigned SLOT_W       = 10;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned DT_W         = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned ENTRY_W      = 4 * WORD_W;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_STEP = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MAX_X = 3'd2,
    CFG_MAX_Y = 3'd3,
    CFG_COUNT = 3'd4
  } cfg_idx_e;

  localparam word_t RST_MIN_X = 32'sd0;
  localparam word_t RST_MIN_Y = 32'sd0;
  localparam word_t RST_MAX_X = 32'sd83886080;
  localparam word_t RST_MAX_Y = 32'sd47185920;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DRAIN,
    ST_READ
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic  load_en;
    logic  step_start;
    logic  step_issue;
    slot_t step_addr;
    logic  rd_issue;
    logic  out_load;
  } ctrl_t;

  // datapath -> controller status
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
    cnt_t step_cnt;
  } status_t;

endpackage

// ----- rtl/core/pbu_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module pbu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/pbu_ctrl.sv -----
// Command sequencer: accepts transactions, walks the entity table on a step.
module pbu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  pbu_pkg::status_t status_i,
  output pbu_pkg::ctrl_t   ctrl_o
);
  import pbu_pkg::*;

  state_e state_q, state_d;
  cnt_t   idx_q, idx_d;
  cnt_t   idx_inc;
  logic   accept;
  cmd_e   cmd;

  assign cmd     = cmd_e'(cmd_i);
  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign idx_inc = idx_q + cnt_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_STEP: begin
              idx_d = '0;
              if (status_i.step_cnt != '0) begin
                state_d = ST_STEP;
              end
            end
            CMD_READ: state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_STEP: begin
        idx_d = idx_inc;
        if (idx_inc == status_i.step_cnt) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    ctrl_o.step_addr = idx_q[SLOT_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctrl_o.load_en    = accept && (cmd == CMD_LOAD);
        ctrl_o.step_start = accept && (cmd == CMD_STEP);
        ctrl_o.rd_issue   = accept && (cmd == CMD_READ);
      end
      ST_STEP:  ctrl_o.step_issue = 1'b1;
      ST_DRAIN: ctrl_o.step_issue = 1'b0;
      ST_READ:  ctrl_o.out_load   = status_i.out_free;
      default:  in_ready_o = 1'b0;
    endcase
  end

`ifndef ASSERT_OFF
  // the update pipeline must be empty whenever a new transaction can enter
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status_i.pipe_busy)
    else $error("transaction accepted with step pipeline busy");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.step_issue |-> (idx_q < status_i.step_cnt))
    else $error("step walked past active count");
`endif

endmodule

// ----- rtl/core/pbu_dpath.sv -----
// Datapath: config registers, entity RAM, Euler update pipeline and result register.
module pbu_dpath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  input  pbu_pkg::slot_t          slot_i,
  input  pbu_pkg::word_t          load_px_i,
  input  pbu_pkg::word_t          load_py_i,
  input  pbu_pkg::word_t          load_vx_i,
  input  pbu_pkg::word_t          load_vy_i,
  input  logic [15:0]             step_dt_i,
  input  pbu_pkg::ctrl_t          ctrl_i,
  output pbu_pkg::status_t        status_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output pbu_pkg::slot_t          out_slot_o,
  output pbu_pkg::word_t          out_px_o,
  output pbu_pkg::word_t          out_py_o,
  output pbu_pkg::word_t          out_vx_o,
  output pbu_pkg::word_t          out_vy_o
);
  import pbu_pkg::*;

  localparam int unsigned PROD_W = WORD_W + DT_W + 1;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef struct packed {
    word_t pos;
    word_t vel;
  } axis_t;

  function automatic word_t neg_sat(word_t v);
    word_t r;
    r = (v == {1'b1, {(WORD_W-1){1'b0}}}) ? {1'b0, {(WORD_W-1){1'b1}}} : -v;
    return r;
  endfunction

  // add floor(prod / 2^16), lower wall first, then upper wall
  function automatic axis_t move_axis(word_t pos, word_t vel, prod_t prod,
                                      word_t lo, word_t hi);
    logic signed [WORD_W+1:0] p;
    axis_t r;
    p = (WORD_W+2)'(pos) + (WORD_W+2)'($signed(prod[PROD_W-1:DT_W]));
    r.pos = p[WORD_W-1:0];
    r.vel = vel;
    if (p < (WORD_W+2)'(lo)) begin
      r.pos = lo;
      r.vel = neg_sat(vel);
    end else if (p > (WORD_W+2)'(hi)) begin
      r.pos = hi;
      r.vel = neg_sat(vel);
    end
    return r;
  endfunction

  // configuration
  word_t min_x_q, min_y_q, max_x_q, max_y_q;
  cnt_t  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= RST_MIN_X;
      min_y_q <= RST_MIN_Y;
      max_x_q <= RST_MAX_X;
      max_y_q <= RST_MAX_Y;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_X: min_x_q <= cfg_data_i;
        CFG_MIN_Y: min_y_q <= cfg_data_i;
        CFG_MAX_X: max_x_q <= cfg_data_i;
        CFG_MAX_Y: max_y_q <= cfg_data_i;
        CFG_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // entity RAM: {px, py, vx, vy}
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic               ram_we, ram_re;
  slot_t              ram_waddr, ram_raddr;

  // update pipeline registers
  logic [DT_W-1:0] dt_q;
  logic            s0_valid_q, s1_valid_q, s2_valid_q;
  slot_t           s0_addr_q, s1_addr_q, s2_addr_q;
  word_t           s1_px_q, s1_py_q, s1_vx_q, s1_vy_q;
  prod_t           s1_prod_x_q, s1_prod_y_q;
  axis_t           s2_x_q, s2_y_q, ax_x, ax_y;
  word_t           rd_px, rd_py, rd_vx, rd_vy;
  prod_t           dt_s;

  // result register
  logic  out_valid_q;
  slot_t rd_slot_q, out_slot_q;
  word_t out_px_q, out_py_q, out_vx_q, out_vy_q;

  assign {rd_px, rd_py, rd_vx, rd_vy} = ram_rdata;
  assign dt_s = prod_t'({1'b0, dt_q});

  assign ram_re    = ctrl_i.step_issue || ctrl_i.rd_issue;
  assign ram_raddr = ctrl_i.step_issue ? ctrl_i.step_addr : slot_i;
  assign ram_we    = ctrl_i.load_en || s2_valid_q;
  assign ram_waddr = s2_valid_q ? s2_addr_q : slot_i;
  assign ram_wdata = s2_valid_q ? {s2_x_q.pos, s2_y_q.pos, s2_x_q.vel, s2_y_q.vel}
                                : {load_px_i, load_py_i, load_vx_i, load_vy_i};

  pbu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTITIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= ctrl_i.step_issue;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign ax_x = move_axis(s1_px_q, s1_vx_q, s1_prod_x_q, min_x_q, max_x_q);
  assign ax_y = move_axis(s1_py_q, s1_vy_q, s1_prod_y_q, min_y_q, max_y_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step_start) begin
      dt_q <= step_dt_i;
    end
    s0_addr_q   <= ctrl_i.step_addr;
    s1_addr_q   <= s0_addr_q;
    s2_addr_q   <= s1_addr_q;
    s1_px_q     <= rd_px;
    s1_py_q     <= rd_py;
    s1_vx_q     <= rd_vx;
    s1_vy_q     <= rd_vy;
    s1_prod_x_q <= prod_t'(rd_vx) * dt_s;
    s1_prod_y_q <= prod_t'(rd_vy) * dt_s;
    s2_x_q      <= ax_x;
    s2_y_q      <= ax_y;
    if (ctrl_i.rd_issue) begin
      rd_slot_q <= slot_i;
    end
    if (ctrl_i.out_load) begin
      out_slot_q <= rd_slot_q;
      out_px_q   <= rd_px;
      out_py_q   <= rd_py;
      out_vx_q   <= rd_vx;
      out_vy_q   <= rd_vy;
    end
  end

  always_comb begin
    status_o.pipe_busy = s0_valid_q || s1_valid_q || s2_valid_q;
    status_o.out_free  = !out_valid_q || out_ready_i;
    status_o.step_cnt  = (count_q > cnt_t'(MAX_ENTITIES)) ? cnt_t'(MAX_ENTITIES) : count_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_slot_o  = out_slot_q;
  assign out_px_o    = out_px_q;
  assign out_py_o    = out_py_q;
  assign out_vx_o    = out_vx_q;
  assign out_vy_o    = out_vy_q;

`ifndef ASSERT_OFF
  // a load never competes with a step write-back for the RAM write port
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.load_en && s2_valid_q))
    else $error("load collided with step write-back");

  // a result is only loaded into a free output register
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");
`endif

endmodule

// ----- rtl/core/particle_bounce_update_core.sv -----
// Particle table with Euler step and wall bounce: top level.
//
// Input channel (in_valid_i/in_ready_o) takes one command per transaction:
// load an entity, step entities 0..active_count-1, or read an entity back.
// Only a read produces a result, on the output channel (out_valid_o/out_ready_i).
// Config channel (cfg_valid_i/cfg_ready_o) writes the wall bounds and the
// active count; it is always ready and should be used while the block is idle.
// Behaviour per command:
//   load  - written on acceptance; the next command may follow in the following cycle
//   read  - RAM read data is registered, then copied into the output register once
//           that register is free; the block is ready again once the result is loaded.
//   step  - for N active entities (nothing moves when N is zero) one entity leaves
//           the RAM read port per cycle into a 3-stage multiply/add/clamp pipeline
//           that writes back through the single RAM write port, then drains.
//   cmd 3 - accepted and ignored.
// A pending result sits in the output register; loads and steps are still
// accepted while it waits, a further read waits until the register frees.
// Reset clears the control state and restores the default bounds and a zero
// count; the entity RAM is not cleared, so entities must be loaded before use.
module particle_bounce_update_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [9:0]          slot_i,
  input  logic signed [31:0]  load_px_i,
  input  logic signed [31:0]  load_py_i,
  input  logic signed [31:0]  load_vx_i,
  input  logic signed [31:0]  load_vy_i,
  input  logic [15:0]         step_dt_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [9:0]          out_slot_o,
  output logic signed [31:0]  out_px_o,
  output logic signed [31:0]  out_py_o,
  output logic signed [31:0]  out_vx_o,
  output logic signed [31:0]  out_vy_o
);
  import pbu_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  assign cfg_ready_o = 1'b1;

  pbu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  pbu_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .slot_i      (slot_i),
    .load_px_i   (load_px_i),
    .load_py_i   (load_py_i),
    .load_vx_i   (load_vx_i),
    .load_vy_i   (load_vy_i),
    .step_dt_i   (step_dt_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_slot_o  (out_slot_o),
    .out_px_o    (out_px_o),
    .out_py_o    (out_py_o),
    .out_vx_o    (out_vx_o),
    .out_vy_o    (out_vy_o)
  );

endmodule

// ----- tb/sv/particle_bounce_update_core_tb.sv -----
// Self-checking testbench for particle_bounce_update_core: directed table, then random phases.
module particle_bounce_update_core_tb;
  import pbu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam word_t       WMAX        = 32'sh7fff_ffff;
  localparam word_t       WMIN        = 32'sh8000_0000;

  typedef struct packed {
    slot_t slot;
    word_t px;
    word_t py;
    word_t vx;
    word_t vy;
  } particle_t;

  typedef struct {
    bit          is_reg;
    cfg_idx_e    reg_idx;
    logic [31:0] reg_val;
    cmd_e        cmd;
    particle_t   body;
    logic [15:0] dt;
    bit          known;
    particle_t   want;
  } dir_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [1:0]         cmd_i       = '0;
  logic [9:0]         slot_i      = '0;
  logic signed [31:0] load_px_i   = '0;
  logic signed [31:0] load_py_i   = '0;
  logic signed [31:0] load_vx_i   = '0;
  logic signed [31:0] load_vy_i   = '0;
  logic [15:0]        step_dt_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [9:0]         out_slot_o;
  logic signed [31:0] out_px_o;
  logic signed [31:0] out_py_o;
  logic signed [31:0] out_vx_o;
  logic signed [31:0] out_vy_o;

  // travels with the payload: a read whose answer is typed into the table
  bit        row_known = 1'b0;
  particle_t row_want  = '0;

  // predictor copy of the particle table and the registers
  word_t tbl_px [MAX_ENTITIES];
  word_t tbl_py [MAX_ENTITIES];
  word_t tbl_vx [MAX_ENTITIES];
  word_t tbl_vy [MAX_ENTITIES];
  word_t wall_lo_x  = RST_MIN_X;
  word_t wall_lo_y  = RST_MIN_Y;
  word_t wall_hi_x  = RST_MAX_X;
  word_t wall_hi_y  = RST_MAX_Y;
  cnt_t  step_count = '0;

  particle_t   pending_reads [$];
  particle_t   read_want;
  dir_row_t    dir_rows [$];
  int unsigned mismatch_count = 0;
  bit          calm           = 1'b0;
  int          hold_left      = 0;

  particle_bounce_update_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .slot_i     (slot_i),
    .load_px_i  (load_px_i),
    .load_py_i  (load_py_i),
    .load_vx_i  (load_vx_i),
    .load_vy_i  (load_vy_i),
    .step_dt_i  (step_dt_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_slot_o (out_slot_o),
    .out_px_o   (out_px_o),
    .out_py_o   (out_py_o),
    .out_vx_o   (out_vx_o),
    .out_vy_o   (out_vy_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned active_span();
    return (step_count > MAX_ENTITIES) ? MAX_ENTITIES : int'(step_count);
  endfunction

  // returns {bounced, new position}; the sum is formed in 64 bits so it cannot wrap
  function automatic logic [32:0] move_axis(word_t pos, word_t vel, logic [15:0] dt,
                                            word_t lo, word_t hi);
    longint p;
    p = longint'(pos) + ((longint'(vel) * longint'({1'b0, dt})) >>> 16);
    if (p < longint'(lo)) return {1'b1, lo};
    if (p > longint'(hi)) return {1'b1, hi};
    return {1'b0, p[31:0]};
  endfunction

  function automatic word_t negate_sat(word_t v);
    return (v == WMIN) ? WMAX : -v;
  endfunction

  function automatic void advance_particles(logic [15:0] dt);
    logic [32:0] r;
    for (int i = 0; i < int'(active_span()); i++) begin
      r = move_axis(tbl_px[i], tbl_vx[i], dt, wall_lo_x, wall_hi_x);
      tbl_px[i] = r[31:0];
      if (r[32]) tbl_vx[i] = negate_sat(tbl_vx[i]);
      r = move_axis(tbl_py[i], tbl_vy[i], dt, wall_lo_y, wall_hi_y);
      tbl_py[i] = r[31:0];
      if (r[32]) tbl_vy[i] = negate_sat(tbl_vy[i]);
    end
  endfunction

  function automatic word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(4))
        0: return WMAX;
        1: return WMIN;
        2: return '0;
        3: return -32'sd1;
        default: return 32'sh0001_0000;
      endcase
    end
    // around the default walls: -256.0 .. 1280.0
    if (pick < 60) return word_t'($urandom_range(32'h0600_0000)) - 32'sh0100_0000;
    return word_t'($urandom());
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic slot_t pick_slot();
    int unsigned span;
    span = (active_span() < 16) ? 16 : active_span();
    if ($urandom_range(3) != 0) return slot_t'($urandom_range(span - 1));
    return slot_t'($urandom_range(MAX_ENTITIES - 1));
  endfunction

  function automatic void add_item(cmd_e c, slot_t s, word_t px, word_t py, word_t vx,
                                   word_t vy, logic [15:0] dt);
    dir_row_t r;
    r.is_reg  = 1'b0;
    r.reg_idx = CFG_MIN_X;
    r.reg_val = '0;
    r.cmd     = c;
    r.body    = {s, px, py, vx, vy};
    r.dt      = dt;
    r.known   = 1'b0;
    r.want    = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_read_known(slot_t s, word_t px, word_t py, word_t vx, word_t vy);
    add_item(CMD_READ, s, px, py, vx, vy, '0);
    dir_rows[dir_rows.size() - 1].known = 1'b1;
    dir_rows[dir_rows.size() - 1].want  = {s, px, py, vx, vy};
  endfunction

  function automatic void add_reg(cfg_idx_e idx, logic [31:0] v);
    add_item(CMD_NONE, '0, '0, '0, '0, '0, '0);
    dir_rows[dir_rows.size() - 1].is_reg  = 1'b1;
    dir_rows[dir_rows.size() - 1].reg_idx = idx;
    dir_rows[dir_rows.size() - 1].reg_val = v;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h (slot %0d)", name, got, want,
                                read_want.slot));
  endtask

  task automatic send_item(cmd_e c, particle_t p, logic [15:0] dt, bit known, particle_t want);
    if (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 34);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    slot_i     <= p.slot;
    load_px_i  <= p.px;
    load_py_i  <= p.py;
    load_vx_i  <= p.vx;
    load_vy_i  <= p.vy;
    step_dt_i  <= dt;
    row_known  <= known;
    row_want   <= want;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // all reads answered, then room for a step that may still be walking the table
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (active_span() + 12) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned ph);
    word_t       lo_x, lo_y, hi_x, hi_y, tmp;
    cnt_t        cnt;
    particle_t   p;
    int unsigned roll, step_pct;
    wait_idle();
    lo_x = rand_word();
    hi_x = rand_word();
    lo_y = rand_word();
    hi_y = rand_word();
    cnt  = cnt_t'($urandom_range(1, 24));
    case (ph)
      0, 4: begin
        lo_x = RST_MIN_X;
        lo_y = RST_MIN_Y;
        hi_x = RST_MAX_X;
        hi_y = RST_MAX_Y;
        if (ph == 4) cnt = cnt_t'(32);
      end
      1: begin
        lo_x = WMIN;
        lo_y = WMIN;
        hi_x = WMAX;
        hi_y = WMAX;
        cnt  = cnt_t'(MAX_ENTITIES);
      end
      2: begin
        // lower wall at or above upper wall on both axes
        if (lo_x <= hi_x) begin tmp = lo_x; lo_x = hi_x; hi_x = tmp; end
        if (lo_y <= hi_y) begin tmp = lo_y; lo_y = hi_y; hi_y = tmp; end
      end
      3: cnt = '1;
      5: cnt = '0;
      6: cnt = cnt_t'($urandom_range(MAX_ENTITIES + 1, 2046));
      default: begin
        if (lo_x > hi_x && $urandom_range(3) != 0) begin tmp = lo_x; lo_x = hi_x; hi_x = tmp; end
        if (lo_y > hi_y && $urandom_range(3) != 0) begin tmp = lo_y; lo_y = hi_y; hi_y = tmp; end
        cnt = cnt_t'($urandom_range(0, 64));
      end
    endcase
    write_reg(CFG_MIN_X, lo_x);
    write_reg(CFG_MIN_Y, lo_y);
    write_reg(CFG_MAX_X, hi_x);
    write_reg(CFG_MAX_Y, hi_y);
    write_reg(CFG_COUNT, 32'(cnt));
    calm = (ph == 3);
    // receiver stalls long enough for the output register and the input to back up
    if (ph == 4) hold_left = 400;
    step_pct = (active_span() > 64) ? 2 : 12;
    repeat (PHASE_ITEMS) begin
      roll = $urandom_range(99);
      p    = {pick_slot(), rand_word(), rand_word(), rand_word(), rand_word()};
      if (roll < step_pct) send_item(CMD_STEP, p, rand_dt(), 1'b0, '0);
      else if (roll < step_pct + 3) send_item(CMD_NONE, p, rand_dt(), 1'b0, '0);
      else if (roll < 55) send_item(CMD_LOAD, p, rand_dt(), 1'b0, '0);
      else send_item(CMD_READ, p, rand_dt(), 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  // predictor: follows each accepted command transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      case (cmd_e'(cmd_i))
        CMD_LOAD: begin
          tbl_px[slot_i] = load_px_i;
          tbl_py[slot_i] = load_py_i;
          tbl_vx[slot_i] = load_vx_i;
          tbl_vy[slot_i] = load_vy_i;
        end
        CMD_STEP: advance_particles(step_dt_i);
        CMD_READ: pending_reads.push_back(row_known ? row_want :
                    particle_t'({slot_i, tbl_px[slot_i], tbl_py[slot_i],
                                 tbl_vx[slot_i], tbl_vy[slot_i]}));
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_X: wall_lo_x = cfg_data_i;
        CFG_MIN_Y: wall_lo_y = cfg_data_i;
        CFG_MAX_X: wall_hi_x = cfg_data_i;
        CFG_MAX_Y: wall_hi_y = cfg_data_i;
        CFG_COUNT: step_count = cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("result for slot %0d with no read outstanding", out_slot_o));
      end else begin
        read_want = pending_reads.pop_front();
        check_field("slot", 32'(out_slot_o), 32'(read_want.slot));
        check_field("px", out_px_o, read_want.px);
        check_field("py", out_py_o, read_want.py);
        check_field("vx", out_vx_o, read_want.vx);
        check_field("vy", out_vy_o, read_want.vy);
      end
    end
  end

  // result side: random back-pressure, plus one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end

  initial begin
    particle_t p;
    add_item(CMD_LOAD, 10'd0, WMAX, WMIN, WMIN, WMAX, 16'd0);
    add_read_known(10'd0, WMAX, WMIN, WMIN, WMAX);
    add_item(CMD_LOAD, 10'd1023, 32'sd0, -32'sd1, 32'sd1, -32'sd1, 16'd0);
    add_read_known(10'd1023, 32'sd0, -32'sd1, 32'sd1, -32'sd1);
    // count is zero out of reset, so this step moves nothing
    add_item(CMD_STEP, 10'd0, '0, '0, '0, '0, 16'hffff);
    add_read_known(10'd0, WMAX, WMIN, WMIN, WMAX);
    add_item(CMD_NONE, 10'd0, WMIN, WMIN, WMIN, WMIN, 16'hffff);
    add_read_known(10'd0, WMAX, WMIN, WMIN, WMAX);
    add_item(CMD_LOAD, 10'd1, 32'sh0280_0000, 32'sh0168_0000, 32'sh0010_0000,
             -32'sh0010_0000, 16'd0);
    // heads for the right and the top wall
    add_item(CMD_LOAD, 10'd2, 32'sh04ff_0000, 32'sh0001_0000, 32'sh00c8_0000,
             -32'sh00c8_0000, 16'd0);
    // most negative velocity: bounce must saturate on negation
    add_item(CMD_LOAD, 10'd3, 32'sh000a_0000, 32'sh000a_0000, WMIN, WMAX, 16'd0);
    add_reg(CFG_COUNT, 32'd4);
    add_item(CMD_STEP, 10'd0, '0, '0, '0, '0, 16'hffff);
    for (int s = 0; s < 4; s++) add_item(CMD_READ, slot_t'(s), '0, '0, '0, '0, '0);
    add_item(CMD_STEP, 10'd0, '0, '0, '0, '0, 16'd0);
    // left wall to the right of the right wall; y walls at the word limits
    add_reg(CFG_MIN_X, 32'h03e8_0000);
    add_reg(CFG_MAX_X, 32'h0064_0000);
    add_reg(CFG_MIN_Y, WMIN);
    add_reg(CFG_MAX_Y, WMAX);
    add_item(CMD_STEP, 10'd0, '0, '0, '0, '0, 16'h8000);
    for (int s = 0; s < 4; s++) add_item(CMD_READ, slot_t'(s), '0, '0, '0, '0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_item(dir_rows[i].cmd, dir_rows[i].body, dir_rows[i].dt, dir_rows[i].known,
                  dir_rows[i].want);
      end
    end

    // fill the whole table so that later reads and steps only touch written entries
    for (int s = 0; s < MAX_ENTITIES; s++) begin
      p = {slot_t'(s), rand_word(), rand_word(), rand_word(), rand_word()};
      send_item(CMD_LOAD, p, rand_dt(), 1'b0, '0);
    end

    for (int unsigned ph = 0; ph < PHASES; ph++) run_phase(ph);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
